### rtl/tcaoq_pkg.sv
// Package for the two-class age-ordered queue.
// Holds the stamp width, operation, status and category codes, the controller state type and the command struct.
// No dependencies.
package tcaoq_pkg;

    // Width of the shared wrapping arrival stamp.
    localparam int STAMP_BITS = 6;

    // Operation codes carried in the kind field.
    localparam logic [1:0] KIND_ENQ       = 2'd0;
    localparam logic [1:0] KIND_DEQ_NAMED = 2'd1;
    localparam logic [1:0] KIND_DEQ_ANY   = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;
    localparam logic [1:0] STATUS_BAD   = 2'd3;

    // Category codes.
    localparam logic CAT_FIRST  = 1'b0;
    localparam logic CAT_SECOND = 1'b1;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage

### rtl/tcaoq_if.sv
// Channel interfaces for the two-class age-ordered queue.
// Request and response channels with valid/ready handshakes; no package dependency.
interface tcaoq_req_if #(
    parameter int TAG_BITS = 16
);
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic                category;
    logic [TAG_BITS-1:0] item_tag;

    modport source (output valid, output kind, output category, output item_tag,
                    input ready);
    modport sink   (input valid, input kind, input category, input item_tag,
                    output ready);
endinterface

interface tcaoq_rsp_if #(
    parameter int TAG_BITS = 16
);
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [TAG_BITS-1:0] out_tag;
    logic                served_category;

    modport source (output valid, output status, output out_tag, output served_category,
                    input ready);
    modport sink   (input valid, input status, input out_tag, input served_category,
                    output ready);
endinterface

### rtl/tcaoq_ctrl.sv
// Controller for the two-class age-ordered queue.
// Sequences capture and execute of one request beat and owns the response valid flag.
// Depends on tcaoq_pkg.
module tcaoq_ctrl
    import tcaoq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    logic        req_fire;

    // A new beat is taken only when the response register is free by the next edge.
    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (req_fire) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Output and command logic.
    always_comb
    begin
        cmd            = '0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        unique case (state_reg)
            ST_IDLE: cmd.capture = req_fire;
            ST_EXEC:
            begin
                cmd.execute    = 1'b1;
                rsp_valid_next = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

    // State and response flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

### rtl/tcaoq_dp.sv
// Datapath for the two-class age-ordered queue.
// Two FIFO memories with pointers and counts, the arrival stamp and the result register.
// Depends on tcaoq_pkg.
module tcaoq_dp
    import tcaoq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
)(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    input  logic [1:0]          kind,
    input  logic                category,
    input  logic [TAG_BITS-1:0] item_tag,
    output logic [1:0]          status,
    output logic [TAG_BITS-1:0] out_tag,
    output logic                served_category
);

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = TAG_BITS + STAMP_BITS;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    // Storage for each category: entries hold the tag above the stamp.
    logic [ENTRY_W-1:0] mem0 [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] mem1 [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rd_reg [2];

    logic [PTR_W-1:0]      head_reg  [2];
    logic [PTR_W-1:0]      tail_reg  [2];
    logic [CNT_W-1:0]      count_reg [2];
    logic [STAMP_BITS-1:0] stamp_reg;

    // Captured request beat.
    logic [1:0]          kind_reg;
    logic                cat_reg;
    logic [TAG_BITS-1:0] tag_reg;

    // Result register.
    logic [1:0]          status_reg;
    logic [TAG_BITS-1:0] out_tag_reg;
    logic                served_reg;

    logic [1:0]            push;
    logic [1:0]            pop;
    logic [1:0]            empty;
    logic [1:0]            full;
    logic [1:0]            status_d;
    logic [TAG_BITS-1:0]   tag_d;
    logic                  served_d;
    logic                  pick;
    logic [STAMP_BITS-1:0] age_diff;
    logic [ENTRY_W-1:0]    wr_data;

    assign empty[0] = (count_reg[0] == '0);
    assign empty[1] = (count_reg[1] == '0);
    assign full[0]  = (count_reg[0] == CNT_W'(QUEUE_DEPTH));
    assign full[1]  = (count_reg[1] == CNT_W'(QUEUE_DEPTH));
    assign wr_data  = {tag_reg, stamp_reg};

    // The first head wins only when it is strictly older within half the stamp range.
    assign age_diff = rd_reg[1][STAMP_BITS-1:0] - rd_reg[0][STAMP_BITS-1:0];

    // Operation decode and result selection.
    always_comb
    begin
        push     = '0;
        pop      = '0;
        status_d = STATUS_EMPTY;
        tag_d    = '0;
        served_d = CAT_FIRST;
        pick     = CAT_FIRST;
        unique case (kind_reg)
            KIND_ENQ:
            begin
                served_d = cat_reg;
                if (full[cat_reg])
                    status_d = STATUS_FULL;
                else
                begin
                    status_d      = STATUS_OK;
                    push[cat_reg] = cmd.execute;
                end
            end
            KIND_DEQ_NAMED:
            begin
                served_d = cat_reg;
                if (!empty[cat_reg])
                begin
                    status_d     = STATUS_OK;
                    tag_d        = rd_reg[cat_reg][ENTRY_W-1:STAMP_BITS];
                    pop[cat_reg] = cmd.execute;
                end
            end
            KIND_DEQ_ANY:
            begin
                if (!(empty[0] && empty[1]))
                begin
                    if (empty[1])
                        pick = CAT_FIRST;
                    else if (empty[0])
                        pick = CAT_SECOND;
                    else if ((age_diff != '0) && !age_diff[STAMP_BITS-1])
                        pick = CAT_FIRST;
                    else
                        pick = CAT_SECOND;
                    status_d  = STATUS_OK;
                    served_d  = pick;
                    tag_d     = rd_reg[pick][ENTRY_W-1:STAMP_BITS];
                    pop[pick] = cmd.execute;
                end
            end
            default:
            begin
                status_d = STATUS_EMPTY;
            end
        endcase
    end

    // Memory writes at the tail and registered reads at the head.
    always_ff @(posedge clk)
    begin
        if (push[0])
            mem0[tail_reg[0]] <= wr_data;
        if (push[1])
            mem1[tail_reg[1]] <= wr_data;
        rd_reg[0] <= mem0[head_reg[0]];
        rd_reg[1] <= mem1[head_reg[1]];
    end

    // Pointers, counts and the arrival stamp.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg[0]  <= '0;
            head_reg[1]  <= '0;
            tail_reg[0]  <= '0;
            tail_reg[1]  <= '0;
            count_reg[0] <= '0;
            count_reg[1] <= '0;
            stamp_reg    <= '0;
        end
        else
        begin
            for (int i = 0; i < 2; i++)
            begin
                if (push[i])
                begin
                    tail_reg[i]  <= ptr_inc(tail_reg[i]);
                    count_reg[i] <= count_reg[i] + 1'b1;
                end
                else if (pop[i])
                begin
                    head_reg[i]  <= ptr_inc(head_reg[i]);
                    count_reg[i] <= count_reg[i] - 1'b1;
                end
            end
            if (push != '0)
                stamp_reg <= stamp_reg + 1'b1;
        end
    end

    // Request capture and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            cat_reg  <= category;
            tag_reg  <= item_tag;
        end
        if (cmd.execute)
        begin
            status_reg  <= status_d;
            out_tag_reg <= tag_d;
            served_reg  <= served_d;
        end
    end

    assign status          = status_reg;
    assign out_tag         = out_tag_reg;
    assign served_category = served_reg;

endmodule

### rtl/two_class_age_ordered_queue.sv
// Two-class age-ordered queue: one request beat in, one response beat out.
// A request beat accepted at one edge executes in the following cycle on the head entries
// read at that edge; its response beat is valid after the next edge and can be taken there.
// No new request is taken while one is being captured and executed; a
// stalled response beat holds off the next request until it is taken.
// Reset clears pointers, counts, the stamp and the controller; storage is not cleared.
module two_class_age_ordered_queue
    import tcaoq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
)(
    input  logic   clk,
    input  logic   rst_n,
    tcaoq_req_if.sink   req,
    tcaoq_rsp_if.source rsp
);

    ctrl_cmd_t cmd;

    // Handshake sequencing.
    tcaoq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Queue storage and result formation.
    tcaoq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .kind            (req.kind),
        .category        (req.category),
        .item_tag        (req.item_tag),
        .status          (rsp.status),
        .out_tag         (rsp.out_tag),
        .served_category (rsp.served_category)
    );

endmodule

### rtl/tcaoq_checker.sv
// Port-level checker for the two-class age-ordered queue, bound to the top level.
// Depends on tcaoq_pkg.
module tcaoq_checker
    import tcaoq_pkg::*;
#(
    parameter int TAG_BITS = 16
)(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [1:0]          status,
    input logic [TAG_BITS-1:0] out_tag
);

    logic req_fire;
    assign req_fire = req_valid && req_ready;

    // A stalled response beat stays valid.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response beat dropped while stalled");

    // After a request beat the block is busy and its response slot is empty.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req_ready && !rsp_valid)
        else $error("request taken while previous one is executing");

    // Every request beat yields its response once the execute state has set the response valid flag.
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |-> ##2 rsp_valid)
        else $error("response missing after request");

    // Only the ok, empty and full status codes appear.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status != STATUS_BAD)
        else $error("undefined status code");

    // A response that dequeued nothing carries a zero tag.
    a_zero_tag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != STATUS_OK |-> out_tag == '0)
        else $error("nonzero tag on a response that dequeued nothing");

endmodule

bind two_class_age_ordered_queue tcaoq_checker #(
    .TAG_BITS (TAG_BITS)
) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .out_tag   (rsp.out_tag)
);
